/* rtl/bocc_pkg.sv */
// ----------------------------------------------------------------------------
// bocc_pkg
// Shared constants and types of the occurrence-block injector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bocc_pkg;

	localparam int SYMS_PER_WORD = 16;
	localparam int NUM_SYMBOLS   = 4;
	localparam int SYM_W         = 2;
	localparam int WORD_W        = 32;
	localparam int VALID_W       = 5;
	localparam int INC_W         = 5;
	localparam int PHASE_W       = 5;

	localparam logic [VALID_W-1:0] MAX_VALID  = 5'd16;
	localparam logic [PHASE_W-1:0] PH_FIRST   = 5'd0;
	localparam logic [PHASE_W-1:0] PH_WORD    = 5'd8;
	localparam logic [PHASE_W-1:0] PH_POST    = 5'd9;
	localparam logic [PHASE_W-1:0] PH_LAST    = 5'd16;

	typedef logic [INC_W-1:0] inc_t;
	typedef logic [NUM_SYMBOLS-1:0][INC_W-1:0] inc_vec_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              block_start;
		logic              last;
	} job_t;

endpackage

`default_nettype wire

/* rtl/bocc_in_if.sv */
// ----------------------------------------------------------------------------
// bocc_in_if
// Request channel carrying packed BWT words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bocc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] packed_word;
	logic [4:0]  valid_symbols;
	logic        last;

	modport source (output valid, output packed_word, output valid_symbols, output last,
		input ready);
	modport sink (input valid, input packed_word, input valid_symbols, input last,
		output ready);
endinterface

`default_nettype wire

/* rtl/bocc_out_if.sv */
// ----------------------------------------------------------------------------
// bocc_out_if
// Result channel carrying passed words and count words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bocc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word;
	logic        is_count_word;
	logic        last_of_run;

	modport source (output valid, output out_word, output is_count_word, output last_of_run,
		input ready);
	modport sink (input valid, input out_word, input is_count_word, input last_of_run,
		output ready);
endinterface

`default_nettype wire

/* rtl/bocc_lane.sv */
// ----------------------------------------------------------------------------
// bocc_lane
// Counts the valid codes of one word that equal this lane's symbol.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bocc_lane #(
	parameter logic [1:0] SYM = 2'd0
) (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic [bocc_pkg::WORD_W-1:0]      word,
	input  wire logic [bocc_pkg::VALID_W-1:0]     nvalid,
	output      bocc_pkg::inc_t                   inc_s1
);

	logic [bocc_pkg::SYMS_PER_WORD-1:0] hits;

	always_comb begin
		for (int i = 0; i < bocc_pkg::SYMS_PER_WORD; i++) begin
			hits[i] = (word[30-2*i +: bocc_pkg::SYM_W] == SYM) &&
				(bocc_pkg::VALID_W'(i) < nvalid);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inc_s1 <= bocc_pkg::INC_W'($countones(hits));
		end
	end

endmodule

`default_nettype wire

/* rtl/bocc_merge.sv */
// ----------------------------------------------------------------------------
// bocc_merge
// Running symbol counts; folds the lane results in as each word moves on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bocc_merge #(
	parameter int COUNT_BITS = 64
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             load,
	input  wire logic                                             clear,
	input  wire bocc_pkg::inc_vec_t                               inc,
	output      logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] pre,
	output      logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] post
);

	logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] counts_q;

	always_comb begin
		for (int s = 0; s < bocc_pkg::NUM_SYMBOLS; s++) begin
			post[s] = counts_q[s] + COUNT_BITS'(inc[s]);
		end
	end

	assign pre = counts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (load) begin
			counts_q <= clear ? '0 : post;
		end
	end

endmodule

`default_nettype wire

/* rtl/bocc_emit.sv */
// ----------------------------------------------------------------------------
// bocc_emit
// Output sequencer: count block at a block start, passed word, final count block when last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bocc_emit #(
	parameter int COUNT_BITS = 64
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             load,
	input  wire bocc_pkg::job_t                                   job,
	input  wire logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] pre,
	input  wire logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] post,
	output      logic                                             free,
	bocc_out_if.source                                            res
);

	logic                                             busy_q;
	logic [bocc_pkg::PHASE_W-1:0]                     phase_q;
	logic [bocc_pkg::PHASE_W-1:0]                     end_q;
	bocc_pkg::job_t                                   job_q;
	logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] pre_q;
	logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] post_q;
	logic                                             finish;
	logic [bocc_pkg::PHASE_W-1:0]                     post_idx;
	logic [COUNT_BITS-1:0]                            cnt;
	logic [63:0]                                      cnt64;
	logic                                             half;

	assign finish = busy_q && res.ready && (phase_q == end_q);
	assign free   = !busy_q || finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= bocc_pkg::PH_FIRST;
			end_q   <= bocc_pkg::PH_WORD;
		end else if (load) begin
			busy_q  <= 1'b1;
			phase_q <= job.block_start ? bocc_pkg::PH_FIRST : bocc_pkg::PH_WORD;
			end_q   <= job.last ? bocc_pkg::PH_LAST : bocc_pkg::PH_WORD;
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (busy_q && res.ready) begin
			phase_q <= phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q  <= job;
			pre_q  <= pre;
			post_q <= post;
		end
	end

	// select the count and half for the current phase
	always_comb begin
		post_idx = phase_q - bocc_pkg::PH_POST;
		if (phase_q < bocc_pkg::PH_WORD) begin
			cnt  = pre_q[phase_q[2:1]];
			half = phase_q[0];
		end else begin
			cnt  = post_q[post_idx[2:1]];
			half = post_idx[0];
		end
		cnt64 = 64'(cnt);
	end

	assign res.valid         = busy_q;
	assign res.is_count_word = (phase_q != bocc_pkg::PH_WORD);
	assign res.last_of_run   = (phase_q == end_q);
	assign res.out_word      = (phase_q == bocc_pkg::PH_WORD) ? job_q.word :
		(half ? cnt64[63:32] : cnt64[31:0]);

endmodule

`default_nettype wire

/* rtl/bwt_occurrence_block_injector_core.sv */
// ----------------------------------------------------------------------------
// bwt_occurrence_block_injector_core
// Inserts occurrence-count blocks into a packed BWT word stream.
// ----------------------------------------------------------------------------
// Each request carries 16 two-bit codes. Four lanes count the codes of each
// symbol into registers; the running counts absorb those results as the word
// moves to the output sequencer. A word that opens a block is preceded by
// eight count words (each count low half first) and a last word is followed
// by eight more; a last word also clears the counts and block position. A
// request enters the lane stage while the previous one is still being sent;
// the output port moves one word per cycle while res.ready is high, so a
// request yields one word, nine at a block start and eight more when last.
`timescale 1ns / 1ps
`default_nettype none

module bwt_occurrence_block_injector_core #(
	parameter int BLOCK_SYMBOLS = 128,
	parameter int COUNT_BITS    = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bocc_in_if.sink    bwt,
	bocc_out_if.source res
);

	localparam int WPB   = (BLOCK_SYMBOLS / 16 == 0) ? 1 : BLOCK_SYMBOLS / 16;
	localparam int WSB_W = (WPB > 1) ? $clog2(WPB) : 1;

	logic                                             accept;
	logic                                             load;
	logic                                             free;
	logic                                             valid_s1;
	bocc_pkg::job_t                                   job_s1;
	logic [WSB_W-1:0]                                 wsb_q;
	logic [bocc_pkg::VALID_W-1:0]                     nvalid;
	bocc_pkg::inc_vec_t                               inc_s1;
	logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] pre;
	logic [bocc_pkg::NUM_SYMBOLS-1:0][COUNT_BITS-1:0] post;

	assign nvalid = (bwt.valid_symbols > bocc_pkg::MAX_VALID) ? bocc_pkg::MAX_VALID :
		bwt.valid_symbols;

	assign load      = valid_s1 && free;
	assign bwt.ready = !valid_s1 || load;
	assign accept    = bwt.valid && bwt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wsb_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (bwt.last || wsb_q == WSB_W'(WPB - 1)) begin
					wsb_q <= '0;
				end else begin
					wsb_q <= wsb_q + 1'b1;
				end
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.word        <= bwt.packed_word;
			job_s1.block_start <= (wsb_q == '0);
			job_s1.last        <= bwt.last;
		end
	end

	for (genvar s = 0; s < bocc_pkg::NUM_SYMBOLS; s++) begin : g_lane
		bocc_lane #(
			.SYM(2'(s))
		) u_lane (
			.clk   (clk),
			.en    (accept),
			.word  (bwt.packed_word),
			.nvalid(nvalid),
			.inc_s1(inc_s1[s])
		);
	end

	bocc_merge #(
		.COUNT_BITS(COUNT_BITS)
	) u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load),
		.clear (job_s1.last),
		.inc   (inc_s1),
		.pre   (pre),
		.post  (post)
	);

	bocc_emit #(
		.COUNT_BITS(COUNT_BITS)
	) u_emit (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load),
		.job   (job_s1),
		.pre   (pre),
		.post  (post),
		.free  (free),
		.res   (res)
	);

endmodule

`default_nettype wire
